// ----- src/icov_pkg.sv -----
// Shared types and constants of the instruction coverage tracker.
`default_nettype none

package icov_pkg;

   // Operation codes of a request.
   localparam logic [2:0] OP_DEFINE = 3'd0;
   localparam logic [2:0] OP_RECORD = 3'd1;
   localparam logic [2:0] OP_BRANCH = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   // Configuration register indexes.
   localparam logic REG_WINDOW_BASE  = 1'b0;
   localparam logic REG_WINDOW_BYTES = 1'b1;

   localparam int             WINDOW_BYTES_W     = 17;
   localparam logic [16:0]    WINDOW_BYTES_RESET = 17'h10000;

   // Outcome flag bits of a slot.
   localparam int FLAG_EXEC      = 0;
   localparam int FLAG_SKIP      = 1;
   localparam int FLAG_TAKEN     = 2;
   localparam int FLAG_NOT_TAKEN = 3;

   // Definition bits of a slot.
   localparam int DEF_INSTR = 0;
   localparam int DEF_COND  = 1;

   // Site tallies.
   localparam int T_UNIQ_EXEC    = 0;
   localparam int T_UNIQ_SKIP    = 1;
   localparam int T_OBS_SITES    = 2;
   localparam int T_OBS_OUTCOMES = 3;
   localparam int T_BOTH         = 4;
   localparam int T_COV_INSTR    = 5;
   localparam int T_TOT_INSTR    = 6;
   localparam int T_COV_BRANCH   = 7;
   localparam int T_TOT_BRANCH   = 8;
   localparam int TALLY_COUNT    = 9;

   // Counter selects of a read.
   localparam logic [3:0] SEL_EXEC       = 4'd0;
   localparam logic [3:0] SEL_SKIP       = 4'd1;
   localparam logic [3:0] SEL_OUTSIDE    = 4'd2;
   localparam logic [3:0] SEL_BRANCHES   = 4'd3;
   localparam logic [3:0] SEL_TAKEN      = 4'd4;
   localparam logic [3:0] SEL_NOT_TAKEN  = 4'd5;
   localparam logic [3:0] SEL_UNIQ_EXEC  = 4'd6;
   localparam logic [3:0] SEL_TOT_BRANCH = 4'd14;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] address;
      logic        outcome;
      logic [3:0]  counter_select;
   } icov_req_type;

   typedef struct packed {
      logic        in_window;
      logic [3:0]  slot_flags;
      logic [63:0] counter_value;
   } icov_rsp_type;

   typedef struct packed {
      logic load;
      logic check;
      logic fetch;
      logic update;
      logic wipe;
      logic wipe_defs;
   } icov_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic sweep_last;
   } icov_stat_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_SWEEP,
      ST_UPDATE
   } icov_state_type;

endpackage

`default_nettype wire

// ----- src/icov_ctrl.sv -----
// Sequencing state machine of the instruction coverage tracker.
`default_nettype none

module icov_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  icov_pkg::icov_stat_type stat,
   output icov_pkg::icov_cmd_type  cmd
);
   import icov_pkg::*;

   icov_state_type state_ff;
   icov_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_INIT: begin
            cmd.wipe      = 1'b1;
            cmd.wipe_defs = 1'b1;
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.is_clear ? ST_SWEEP : ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_SWEEP: begin
            cmd.wipe = 1'b1;
            if (stat.sweep_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/icov_dpath.sv -----
// Datapath of the instruction coverage tracker: window check, slot memories, counters.
`default_nettype none

module icov_dpath #(
   parameter int NUM_SLOTS = 32768
) (
   input  logic                    clock,
   input  logic                    reset,
   input  icov_pkg::icov_req_type  req_data,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [31:0]             csr_wdata,
   input  icov_pkg::icov_cmd_type  cmd,
   output icov_pkg::icov_stat_type stat,
   output logic                    rsp_valid,
   output icov_pkg::icov_rsp_type  rsp_data
);
   import icov_pkg::*;

   localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int TALLY_W = $clog2(2 * NUM_SLOTS + 1);

   // Definition marks survive a clear; outcome flags do not.
   logic [1:0] def_mem [NUM_SLOTS];
   logic [3:0] flag_mem [NUM_SLOTS];

   logic [31:0]          base_ff;
   logic [16:0]          bytes_ff;
   icov_req_type         req_ff;
   logic                 inside_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    sweep_ff;
   logic [1:0]           def_rd_ff;
   logic [3:0]           flag_rd_ff;
   logic [63:0]          exec_ff;
   logic [63:0]          skip_ff;
   logic [63:0]          outside_ff;
   logic [63:0]          taken_ff;
   logic [63:0]          not_taken_ff;
   logic [TALLY_W-1:0]   tally_ff [TALLY_COUNT];
   logic                 rsp_valid_ff;
   icov_rsp_type         rsp_ff;

   logic [31:0]          offset;
   logic                 inside_in;
   logic [1:0]           def_new;
   logic [3:0]           flag_new;
   logic [TALLY_COUNT-1:0] tally_inc;
   logic                 exec_inc;
   logic                 skip_inc;
   logic                 outside_inc;
   logic                 taken_inc;
   logic                 not_taken_inc;
   logic                 mark_we;
   logic                 mem_addr_sel;
   logic [SLOT_W-1:0]    mem_addr;
   logic [3:0]           tally_idx;
   logic [63:0]          counter_mux;
   icov_rsp_type         rsp_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         bytes_ff <= WINDOW_BYTES_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WINDOW_BASE:  base_ff  <= csr_wdata;
            REG_WINDOW_BYTES: bytes_ff <= csr_wdata[WINDOW_BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // Window test on the captured request.
   assign offset    = req_ff.address - base_ff;
   assign inside_in = !req_ff.address[0]
                      && (req_ff.address >= base_ff)
                      && (offset < {15'd0, bytes_ff})
                      && ({1'b0, offset[31:1]} < 32'(NUM_SLOTS));

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.check) begin
         inside_ff <= inside_in;
         slot_ff   <= offset[SLOT_W:1];
      end
   end

   // Sweep address, shared by the power-up wipe and the clear operation.
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.wipe) begin
         if (stat.sweep_last) sweep_ff <= '0;
         else                 sweep_ff <= sweep_ff + 1'b1;
      end
   end

   assign stat.sweep_last = (sweep_ff == SLOT_W'(NUM_SLOTS - 1));
   assign stat.is_clear   = (req_ff.op == OP_CLEAR);

   assign mem_addr_sel = cmd.wipe;
   assign mem_addr     = mem_addr_sel ? sweep_ff : slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.wipe_defs)    def_mem[mem_addr] <= '0;
      else if (mark_we)     def_mem[mem_addr] <= def_new;
   end

   always_ff @(posedge clock) begin
      if (cmd.wipe)         flag_mem[mem_addr] <= '0;
      else if (mark_we)     flag_mem[mem_addr] <= flag_new;
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         def_rd_ff  <= def_mem[slot_ff];
         flag_rd_ff <= flag_mem[slot_ff];
      end
   end

   // New slot marks and the tally and counter increments of one operation.
   always_comb begin
      def_new       = def_rd_ff;
      flag_new      = flag_rd_ff;
      tally_inc     = '0;
      exec_inc      = 1'b0;
      skip_inc      = 1'b0;
      outside_inc   = 1'b0;
      taken_inc     = 1'b0;
      not_taken_inc = 1'b0;
      unique case (req_ff.op)
         OP_DEFINE: begin
            if (inside_ff) begin
               def_new[DEF_INSTR] = 1'b1;
               if (!def_rd_ff[DEF_INSTR]) begin
                  tally_inc[T_TOT_INSTR] = 1'b1;
                  tally_inc[T_COV_INSTR] = flag_rd_ff[FLAG_EXEC];
               end
               if (req_ff.outcome && !def_rd_ff[DEF_COND]) begin
                  def_new[DEF_COND]       = 1'b1;
                  tally_inc[T_TOT_BRANCH] = 1'b1;
                  tally_inc[T_COV_BRANCH] = flag_rd_ff[FLAG_TAKEN]
                                            | flag_rd_ff[FLAG_NOT_TAKEN];
               end
            end
         end
         OP_RECORD: begin
            exec_inc = req_ff.outcome;
            skip_inc = !req_ff.outcome;
            if (!inside_ff) begin
               outside_inc = 1'b1;
            end else if (req_ff.outcome) begin
               if (!flag_rd_ff[FLAG_EXEC]) begin
                  flag_new[FLAG_EXEC]    = 1'b1;
                  tally_inc[T_UNIQ_EXEC] = 1'b1;
                  tally_inc[T_COV_INSTR] = def_rd_ff[DEF_INSTR];
               end
            end else if (!flag_rd_ff[FLAG_SKIP]) begin
               flag_new[FLAG_SKIP]    = 1'b1;
               tally_inc[T_UNIQ_SKIP] = 1'b1;
            end
         end
         OP_BRANCH: begin
            if (inside_ff) begin
               taken_inc     = req_ff.outcome;
               not_taken_inc = !req_ff.outcome;
               if (!flag_rd_ff[FLAG_TAKEN] && !flag_rd_ff[FLAG_NOT_TAKEN]) begin
                  tally_inc[T_OBS_SITES]  = 1'b1;
                  tally_inc[T_COV_BRANCH] = def_rd_ff[DEF_COND];
               end
               if (req_ff.outcome && !flag_rd_ff[FLAG_TAKEN]) begin
                  flag_new[FLAG_TAKEN]      = 1'b1;
                  tally_inc[T_OBS_OUTCOMES] = 1'b1;
                  tally_inc[T_BOTH]         = flag_rd_ff[FLAG_NOT_TAKEN];
               end
               if (!req_ff.outcome && !flag_rd_ff[FLAG_NOT_TAKEN]) begin
                  flag_new[FLAG_NOT_TAKEN]  = 1'b1;
                  tally_inc[T_OBS_OUTCOMES] = 1'b1;
                  tally_inc[T_BOTH]         = flag_rd_ff[FLAG_TAKEN];
               end
            end
         end
         default: ;
      endcase
   end

   assign mark_we = cmd.update && inside_ff
                    && ((req_ff.op == OP_DEFINE) || (req_ff.op == OP_RECORD)
                        || (req_ff.op == OP_BRANCH));

   // Event counters and site tallies.
   always_ff @(posedge clock) begin
      if (reset) begin
         exec_ff      <= '0;
         skip_ff      <= '0;
         outside_ff   <= '0;
         taken_ff     <= '0;
         not_taken_ff <= '0;
         for (int i = 0; i < TALLY_COUNT; i++) tally_ff[i] <= '0;
      end else if (cmd.update) begin
         if (stat.is_clear) begin
            exec_ff      <= '0;
            skip_ff      <= '0;
            outside_ff   <= '0;
            taken_ff     <= '0;
            not_taken_ff <= '0;
            for (int i = 0; i < TALLY_COUNT; i++) begin
               if (i != T_TOT_INSTR && i != T_TOT_BRANCH) tally_ff[i] <= '0;
            end
         end else begin
            exec_ff      <= exec_ff + 64'(exec_inc);
            skip_ff      <= skip_ff + 64'(skip_inc);
            outside_ff   <= outside_ff + 64'(outside_inc);
            taken_ff     <= taken_ff + 64'(taken_inc);
            not_taken_ff <= not_taken_ff + 64'(not_taken_inc);
            for (int i = 0; i < TALLY_COUNT; i++) begin
               tally_ff[i] <= tally_ff[i] + TALLY_W'(tally_inc[i]);
            end
         end
      end
   end

   assign tally_idx = req_ff.counter_select - SEL_UNIQ_EXEC;

   always_comb begin
      case (req_ff.counter_select) inside
         SEL_EXEC:      counter_mux = exec_ff;
         SEL_SKIP:      counter_mux = skip_ff;
         SEL_OUTSIDE:   counter_mux = outside_ff;
         SEL_BRANCHES:  counter_mux = taken_ff + not_taken_ff;
         SEL_TAKEN:     counter_mux = taken_ff;
         SEL_NOT_TAKEN: counter_mux = not_taken_ff;
         [SEL_UNIQ_EXEC:SEL_TOT_BRANCH]: counter_mux = 64'(tally_ff[tally_idx]);
         default:       counter_mux = '0;
      endcase
   end

   always_comb begin
      rsp_in               = '0;
      rsp_in.in_window     = inside_ff
                             && ((req_ff.op == OP_DEFINE) || (req_ff.op == OP_RECORD)
                                 || (req_ff.op == OP_BRANCH) || (req_ff.op == OP_READ));
      if (req_ff.op == OP_READ) begin
         rsp_in.counter_value = counter_mux;
         if (inside_ff) rsp_in.slot_flags = flag_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
      end
      if (cmd.update) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- src/instruction_coverage_tracker.sv -----
// Top level of the instruction coverage tracker.
//
// A request is taken at a rising edge where start is high and busy is low. It
// carries an operation (define, record, branch, clear or read), a byte address,
// an outcome bit and a counter select. Each request gives exactly one response,
// shown on rsp_data for the single cycle in which rsp_valid is high; the
// receiver cannot hold it off. The csr_ port writes the window base (index 0)
// and window length (index 1) and should only be used while busy is low.
// Define, record, branch and read requests pass through a window check, a slot
// memory read and a read-modify-write of the slot and the counters, then show
// their response. The next request may be accepted in the cycle in which the
// response is shown, but not before. A clear writes every slot of the outcome
// memory, one slot per cycle, then updates the counters and shows its response.
// After reset the block wipes both slot memories and holds busy high until the
// wipe is done; configuration writes are taken during that time.
`default_nettype none

module instruction_coverage_tracker #(
   parameter int NUM_SLOTS = 32768
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  icov_pkg::icov_req_type req_data,
   output logic                   rsp_valid,
   output icov_pkg::icov_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [31:0]            csr_wdata
);
   import icov_pkg::*;

   icov_cmd_type  cmd;
   icov_stat_type stat;

   icov_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   icov_dpath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- src/icov_checker.sv -----
// Port-level checks of the instruction coverage tracker and their binding.
`default_nettype none

module icov_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input icov_pkg::icov_rsp_type rsp_data
);
   import icov_pkg::*;

   // An accepted request keeps the block busy until its response.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting a request");

   // Responses are never shown in two consecutive cycles.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // A response is shown only once the block is free again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   // Outcome flags only come from a slot inside the window.
   a_flags_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_window |-> rsp_data.slot_flags == '0)
      else $error("slot flags reported outside the window");

endmodule

bind instruction_coverage_tracker icov_checker u_icov_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the instruction coverage tracker, with its own coverage predictor.
import icov_pkg::*;

class coverage_scoreboard;
   localparam int SLOT_TOTAL = 32768;

   bit [31:0]    base = '0;
   bit [16:0]    bytes = WINDOW_BYTES_RESET;
   bit [3:0]     flags [SLOT_TOTAL];
   bit [1:0]     defs [SLOT_TOTAL];
   bit [63:0]    executed = '0;
   bit [63:0]    skipped = '0;
   bit [63:0]    outside = '0;
   bit [63:0]    taken = '0;
   bit [63:0]    not_taken = '0;
   bit [63:0]    tally [TALLY_COUNT];
   icov_rsp_type awaited_rsp [$];
   int           error_count = 0;

   function void write_register(input logic idx, input bit [31:0] value);
      if (idx == REG_WINDOW_BASE) begin
         base = value;
      end else begin
         bytes = value[16:0];
      end
   endfunction

   function bit [63:0] counter_of(input bit [3:0] sel);
      case (sel)
         SEL_EXEC:      return executed;
         SEL_SKIP:      return skipped;
         SEL_OUTSIDE:   return outside;
         SEL_BRANCHES:  return taken + not_taken;
         SEL_TAKEN:     return taken;
         SEL_NOT_TAKEN: return not_taken;
         default: begin
            if (sel >= SEL_UNIQ_EXEC && sel <= SEL_TOT_BRANCH) return tally[sel - SEL_UNIQ_EXEC];
            return '0;
         end
      endcase
   endfunction

   function icov_rsp_type coverage_step(input icov_req_type r);
      icov_rsp_type rsp;
      bit           in_win;
      int unsigned  slot;
      bit [31:0]    off;
      int           hit;
      int           other;
      rsp = '0;
      in_win = 1'b0;
      slot = 0;
      off = r.address - base;
      if (!r.address[0] && r.address >= base && off < bytes && (off >> 1) < SLOT_TOTAL) begin
         in_win = 1'b1;
         slot = off >> 1;
      end
      case (r.op)
         OP_DEFINE: begin
            if (in_win) begin
               if (!defs[slot][DEF_INSTR]) begin
                  defs[slot][DEF_INSTR] = 1'b1;
                  tally[T_TOT_INSTR]++;
                  if (flags[slot][FLAG_EXEC]) tally[T_COV_INSTR]++;
               end
               if (r.outcome && !defs[slot][DEF_COND]) begin
                  defs[slot][DEF_COND] = 1'b1;
                  tally[T_TOT_BRANCH]++;
                  if (flags[slot][FLAG_TAKEN] || flags[slot][FLAG_NOT_TAKEN])
                     tally[T_COV_BRANCH]++;
               end
            end
         end
         OP_RECORD: begin
            if (!in_win) begin
               outside++;
            end else begin
               hit = r.outcome ? FLAG_EXEC : FLAG_SKIP;
               if (!flags[slot][hit]) begin
                  flags[slot][hit] = 1'b1;
                  if (r.outcome) begin
                     tally[T_UNIQ_EXEC]++;
                     if (defs[slot][DEF_INSTR]) tally[T_COV_INSTR]++;
                  end else begin
                     tally[T_UNIQ_SKIP]++;
                  end
               end
            end
            if (r.outcome) executed++;
            else skipped++;
         end
         OP_BRANCH: begin
            if (in_win) begin
               hit = r.outcome ? FLAG_TAKEN : FLAG_NOT_TAKEN;
               other = r.outcome ? FLAG_NOT_TAKEN : FLAG_TAKEN;
               if (!flags[slot][FLAG_TAKEN] && !flags[slot][FLAG_NOT_TAKEN]) begin
                  tally[T_OBS_SITES]++;
                  if (defs[slot][DEF_COND]) tally[T_COV_BRANCH]++;
               end
               if (!flags[slot][hit]) begin
                  flags[slot][hit] = 1'b1;
                  tally[T_OBS_OUTCOMES]++;
                  if (flags[slot][other]) tally[T_BOTH]++;
               end
               if (r.outcome) taken++;
               else not_taken++;
            end
         end
         OP_CLEAR: begin
            executed = '0;
            skipped = '0;
            outside = '0;
            taken = '0;
            not_taken = '0;
            foreach (tally[i])
               if (i != T_TOT_INSTR && i != T_TOT_BRANCH) tally[i] = '0;
            foreach (flags[i]) flags[i] = '0;
            in_win = 1'b0;
         end
         OP_READ: begin
            if (in_win) rsp.slot_flags = flags[slot];
            rsp.counter_value = counter_of(r.counter_select);
         end
         default: in_win = 1'b0;
      endcase
      rsp.in_window = in_win;
      return rsp;
   endfunction

   function void note_request(input icov_req_type r);
      awaited_rsp.push_back(coverage_step(r));
   endfunction

   function void check_response(input icov_rsp_type got);
      icov_rsp_type want;
      if (awaited_rsp.size() == 0) begin
         $display("%0t unexpected response: expected none actual %h", $time, got);
         error_count++;
         return;
      end
      want = awaited_rsp.pop_front();
      if (got.in_window !== want.in_window) begin
         $display("%0t in_window: expected %0d actual %0d", $time, want.in_window, got.in_window);
         error_count++;
      end
      if (got.slot_flags !== want.slot_flags) begin
         $display("%0t slot_flags: expected %h actual %h", $time, want.slot_flags,
                  got.slot_flags);
         error_count++;
      end
      if (got.counter_value !== want.counter_value) begin
         $display("%0t counter_value: expected %h actual %h", $time, want.counter_value,
                  got.counter_value);
         error_count++;
      end
   endfunction

   function int pending();
      return awaited_rsp.size();
   endfunction
endclass

module tb_top;
   localparam int SLOTS = 32768;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int PHASES = 7;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   icov_req_type req_data;
   logic         rsp_valid;
   icov_rsp_type rsp_data;
   logic         csr_we;
   logic         csr_index;
   logic [31:0]  csr_wdata;

   coverage_scoreboard sb;
   bit [31:0] cur_base = '0;
   bit [16:0] cur_bytes = WINDOW_BYTES_RESET;
   int        clears_left = 8;
   bit        burst = 1'b0;
   int        cycles = 0;

   bit [31:0] phase_base [PHASES] = '{32'h2000_0000, 32'hFFFF_0000, 32'hFFFE_0000,
                                      32'h0000_1235, 32'hFFFF_FFFE, 32'h0000_4000,
                                      32'h0000_0000};
   // The last length carries junk above bit 16, which the register must drop.
   bit [31:0] phase_bytes [PHASES] = '{32'd256, 32'd65536, 32'h0001_FFFF, 32'd101, 32'd2,
                                       32'd0, 32'hFFFE_0040};
   int        phase_items [PHASES] = '{250, 250, 250, 200, 150, 100, 250};

   instruction_coverage_tracker #(.NUM_SLOTS(SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_response(rsp_data);
   end

   function automatic icov_req_type make_req(input logic [2:0] op, input bit [31:0] address,
                                             input bit outcome, input bit [3:0] sel);
      icov_req_type r;
      r.op = op;
      r.address = address;
      r.outcome = outcome;
      r.counter_select = sel;
      return r;
   endfunction

   // Start stays high across back-to-back requests, so every return is followed by exactly
   // one assignment to start in the same step.
   task automatic issue_request(input icov_req_type r, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(r);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure_window(input bit [31:0] base, input bit [31:0] bytes);
      csr_we <= 1'b1;
      csr_index <= REG_WINDOW_BASE;
      csr_wdata <= base;
      @(posedge clock);
      sb.write_register(REG_WINDOW_BASE, base);
      csr_index <= REG_WINDOW_BYTES;
      csr_wdata <= bytes;
      @(posedge clock);
      sb.write_register(REG_WINDOW_BYTES, bytes);
      csr_we <= 1'b0;
      cur_base = base;
      cur_bytes = bytes[16:0];
   endtask

   // Mostly slots near either end of the window, so that the same slots are defined,
   // recorded and read again; the rest are odd, boundary or arbitrary addresses.
   function automatic bit [31:0] pick_address();
      int        lim;
      int        span;
      int        slot;
      int        r;
      bit [31:0] addr;
      lim = cur_bytes / 2;
      if (lim > SLOTS) lim = SLOTS;
      r = $urandom_range(0, 99);
      if (lim == 0 || r >= 90) return $urandom;
      span = (lim < 16) ? lim : 16;
      if ($urandom_range(0, 1)) slot = $urandom_range(0, span - 1);
      else slot = lim - 1 - $urandom_range(0, span - 1);
      addr = cur_base + 2 * slot + cur_base[0];
      if (r < 70) return addr;
      if (r < 80) return addr | 32'd1;
      case ($urandom_range(0, 3))
         0: return cur_base + cur_bytes;
         1: return cur_base + cur_bytes + 1;
         2: return cur_base - 2;
         default: return cur_base + 2 * SLOTS;
      endcase
   endfunction

   function automatic icov_req_type random_request();
      int         r;
      logic [2:0] op;
      r = $urandom_range(0, 99);
      if (r < 18) op = OP_DEFINE;
      else if (r < 45) op = OP_RECORD;
      else if (r < 70) op = OP_BRANCH;
      else if (r < 97) op = OP_READ;
      else op = 3'($urandom_range(5, 7));
      // A clear sweeps the whole table, so only a handful are allowed.
      if (clears_left > 0 && $urandom_range(0, 199) == 0) begin
         op = OP_CLEAR;
         clears_left--;
      end
      return make_req(op, pick_address(), 1'($urandom_range(0, 1)),
                      4'($urandom_range(0, 15)));
   endfunction

   task automatic run_directed();
      icov_req_type list [$];
      bit [3:0]     sels [8] = '{4'd0, 4'd3, 4'd6, 4'd10, 4'd11, 4'd13, 4'd14, 4'd15};
      bit [31:0]    spots [4] = '{32'h0, 32'h4, 32'h6, 32'hFFFE};
      list.push_back(make_req(OP_DEFINE, 32'h0, 1'b1, 4'd0));
      list.push_back(make_req(OP_DEFINE, 32'h0, 1'b1, 4'd0));
      list.push_back(make_req(OP_DEFINE, 32'hFFFE, 1'b0, 4'd0));
      list.push_back(make_req(OP_DEFINE, 32'h1_0000, 1'b1, 4'd0));
      list.push_back(make_req(OP_DEFINE, 32'h1, 1'b1, 4'd0));
      list.push_back(make_req(OP_RECORD, 32'h0, 1'b1, 4'd0));
      list.push_back(make_req(OP_RECORD, 32'h0, 1'b0, 4'd0));
      list.push_back(make_req(OP_RECORD, 32'h8000_0000, 1'b1, 4'd0));
      list.push_back(make_req(OP_RECORD, 32'hFFFF_FFFF, 1'b0, 4'd0));
      list.push_back(make_req(OP_BRANCH, 32'h0, 1'b1, 4'd0));
      list.push_back(make_req(OP_BRANCH, 32'h0, 1'b0, 4'd0));
      list.push_back(make_req(OP_BRANCH, 32'hFFFF_FFFF, 1'b1, 4'd0));
      // Execution before definition, and an outcome before the site is declared conditional.
      list.push_back(make_req(OP_RECORD, 32'h4, 1'b1, 4'd0));
      list.push_back(make_req(OP_DEFINE, 32'h4, 1'b0, 4'd0));
      list.push_back(make_req(OP_BRANCH, 32'h6, 1'b0, 4'd0));
      list.push_back(make_req(OP_DEFINE, 32'h6, 1'b1, 4'd0));
      list.push_back(make_req(3'd7, 32'hFFFF_FFFF, 1'b1, 4'd15));
      foreach (sels[i]) list.push_back(make_req(OP_READ, spots[i % 4], 1'b0, sels[i]));
      list.push_back(make_req(OP_CLEAR, 32'h0, 1'b0, 4'd0));
      list.push_back(make_req(OP_READ, 32'h0, 1'b0, 4'd12));
      list.push_back(make_req(OP_READ, 32'h6, 1'b1, 4'd14));
      foreach (list[i]) issue_request(list[i], (i % 3 == 0) ? 0 : $urandom_range(0, 9));
   endtask

   task automatic run_random(input int count);
      int gap;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 29) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 9);
         issue_request(random_request(), gap);
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = REG_WINDOW_BASE;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // The block wipes its slot memories after reset and holds busy until done.
      do @(posedge clock); while (busy !== 1'b0);
      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         configure_window(phase_base[p], phase_bytes[p]);
         run_random(phase_items[p]);
      end
      wait_idle();
      repeat (6) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
